// ===== hdl/obod_pkg.sv =====
`timescale 1ns / 1ps

package obod_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * COORD_W;
  localparam int NUM_W = COORD_W + FRAC_W;
  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    coord_t comp_x;
    coord_t comp_y;
    coord_t comp_z;
    logic evaluate;
  } item_t;

  typedef struct packed {
    logic overlap;
    coord_t depth;
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
  } result_t;

  typedef struct packed {
    logic neg;
    logic [PROD_W-1:0] mag;
  } prod_t;

  typedef enum logic {
    MODE_SUM,
    MODE_DIFF
  } merge_mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VDIFF,
    S_TDOT,
    S_RDOT,
    S_FA,
    S_FB_RA,
    S_FB_T,
    S_E_RA,
    S_E_RB,
    S_E_T,
    S_CHK1,
    S_CHK2,
    S_NSEL,
    S_CROSS,
    S_NDOT,
    S_NGO,
    S_NWAIT,
    S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQ,
    N_SQRT,
    N_DIV,
    N_DONE
  } norm_state_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic coord_t fadd(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  function automatic coord_t fsub(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  function automatic coord_t fneg(coord_t a);
    return fsub('0, a);
  endfunction

  function automatic coord_t fabsv(coord_t a);
    return a[COORD_W-1] ? fneg(a) : a;
  endfunction

  function automatic coord_t fmul_finish(prod_t p);
    logic [PROD_W-1:0] sh;
    logic [PROD_W-1:0] lim;
    sh = p.mag >> FRAC_W;
    lim = PROD_W'({1'b0, {(COORD_W-1){1'b1}}}) + PROD_W'(p.neg);
    if (sh > lim) begin
      sh = lim;
    end
    if (p.neg) begin
      sh = ~sh + PROD_W'(1);
    end
    return sh[COORD_W-1:0];
  endfunction

endpackage

// ===== hdl/obod_lane.sv =====
`timescale 1ns / 1ps

module obod_lane
  import obod_pkg::*;
(
  input  logic   clk,
  input  coord_t op_a,
  input  coord_t op_b,
  output prod_t  prod
);

  logic [COORD_W-1:0] ua;
  logic [COORD_W-1:0] ub;

  assign ua = op_a[COORD_W-1] ? (~op_a + COORD_W'(1)) : op_a;
  assign ub = op_b[COORD_W-1] ? (~op_b + COORD_W'(1)) : op_b;

  always_ff @(posedge clk) begin
    prod.neg <= op_a[COORD_W-1] ^ op_b[COORD_W-1];
    prod.mag <= PROD_W'(ua) * PROD_W'(ub);
  end

endmodule

// ===== hdl/obod_merge.sv =====
`timescale 1ns / 1ps

module obod_merge
  import obod_pkg::*;
(
  input  prod_t       prod [3],
  input  merge_mode_t mode,
  output coord_t      y
);

  coord_t p0;
  coord_t p1;
  coord_t p2;

  assign p0 = fmul_finish(prod[0]);
  assign p1 = fmul_finish(prod[1]);
  assign p2 = fmul_finish(prod[2]);

  always_comb begin
    case (mode)
      MODE_DIFF: y = fsub(p0, p1);
      default:   y = fadd(fadd(p0, p1), p2);
    endcase
  end

endmodule

// ===== hdl/obod_norm.sv =====
`timescale 1ns / 1ps

module obod_norm
  import obod_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  vec_t n_in,
  output vec_t n_out,
  output logic done
);

  norm_state_t state, state_next;

  logic [2:0] sgn;
  logic [COORD_W-1:0] u [3];
  logic [COORD_W-1:0] m;
  logic [COORD_W-1:0] ua [3];
  logic [COORD_W-1:0] ma;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] rt;
  logic [PROD_W-1:0] bitv;
  logic [PROD_W-1:0] rtb;
  logic [PROD_W-1:0] sq;
  logic [5:0] cnt;
  logic [NUM_W-1:0] num [3];
  logic [COORD_W-1:0] rem [3];
  logic [NUM_W-1:0] q [3];
  logic [COORD_W-1:0] len;

  localparam logic [5:0] SQ_LAST = 6'd2;
  localparam logic [5:0] SQRT_LAST = 6'(PROD_W / 2 - 1);
  localparam logic [5:0] DIV_LAST = 6'(NUM_W - 1);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ua[j] = n_in[j][COORD_W-1] ? (~n_in[j] + COORD_W'(1)) : n_in[j];
    end
    ma = ua[0];
    if (ua[1] > ma) ma = ua[1];
    if (ua[2] > ma) ma = ua[2];
  end

  assign sq = PROD_W'(u[cnt[1:0]]) * PROD_W'(u[cnt[1:0]]);
  assign rtb = rt + bitv;
  assign len = rt[COORD_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE: if (start) state_next = N_SCALE;
      N_SCALE: begin
        if (m == '0) begin
          state_next = N_DONE;
        end else if (!m[COORD_W-1] && m[COORD_W-2]) begin
          state_next = N_SQ;
        end
      end
      N_SQ: if (cnt == SQ_LAST) state_next = N_SQRT;
      N_SQRT: if (cnt == SQRT_LAST) state_next = N_DIV;
      N_DIV: if (cnt == DIV_LAST) state_next = N_DONE;
      N_DONE: state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  always_comb begin
    done = (state == N_DONE);
    for (int j = 0; j < 3; j++) begin
      n_out[j] = sgn[j] ? (~q[j][COORD_W-1:0] + COORD_W'(1)) : q[j][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    logic [COORD_W:0] rs;
    case (state)
      N_IDLE: begin
        if (start) begin
          for (int j = 0; j < 3; j++) begin
            sgn[j] <= n_in[j][COORD_W-1];
            u[j] <= ua[j];
            q[j] <= '0;
          end
          m <= ma;
        end
      end
      N_SCALE: begin
        if (m[COORD_W-1]) begin
          for (int j = 0; j < 3; j++) u[j] <= u[j] >> 1;
          m <= m >> 1;
        end else if (!m[COORD_W-2] && m != '0) begin
          for (int j = 0; j < 3; j++) u[j] <= u[j] << 1;
          m <= m << 1;
        end else begin
          acc <= '0;
          cnt <= '0;
        end
      end
      N_SQ: begin
        acc <= acc + sq;
        if (cnt == SQ_LAST) begin
          cnt <= '0;
          rt <= '0;
          bitv <= PROD_W'(1) << (PROD_W - 2);
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      N_SQRT: begin
        if (acc >= rtb) begin
          acc <= acc - rtb;
          rt <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        bitv <= bitv >> 2;
        if (cnt == SQRT_LAST) begin
          cnt <= '0;
          for (int j = 0; j < 3; j++) begin
            num[j] <= {u[j], {FRAC_W{1'b0}}};
            rem[j] <= '0;
            q[j] <= '0;
          end
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      N_DIV: begin
        for (int j = 0; j < 3; j++) begin
          rs = {rem[j], num[j][NUM_W-1]};
          if (rs >= {1'b0, len}) begin
            rem[j] <= COORD_W'(rs - {1'b0, len});
            q[j] <= {q[j][NUM_W-2:0], 1'b1};
          end else begin
            rem[j] <= rs[COORD_W-1:0];
            q[j] <= {q[j][NUM_W-2:0], 1'b0};
          end
          num[j] <= num[j] << 1;
        end
        cnt <= cnt + 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/oriented_box_overlap_depth.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_ready   item_data (item_t)
// res       out        res_valid / res_ready     res_data (result_t)
//
// A load without evaluate only writes one slot of the vector store. An evaluating
// transaction runs up to 52 steps through the three multiplier lanes, a check per axis,
// normal scaling, a square root and a divide; it ends at the first separating axis,
// and the normaliser ends early for a zero normal.
// Reset clears the sequencer and the result valid flag; the vector store is
// undefined until written. A stalled result is held while loads are still accepted.

module oriented_box_overlap_depth
  import obod_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item_data,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  localparam logic [3:0] AX_FB = 4'd3;
  localparam logic [3:0] AX_EDGE = 4'd6;
  localparam logic [3:0] AX_LAST = 4'd14;
  localparam logic [3:0] CNT_ROW = 4'd2;
  localparam logic [3:0] CNT_MAT = 4'd8;

  seq_state_t state, state_next;

  coord_t vs [3 * NUM_SLOTS];
  vec_t ext_a, ctr_a, ext_b, ctr_b;
  vec_t bas_a [3];
  vec_t bas_b [3];

  vec_t v_r, t_r, n_r;
  vec_t rm [3];
  coord_t ra_r, rb_r, tax_r, sum_r, best_depth, depth_c;
  logic [3:0] best_ax, ax, cnt, ax_n;
  logic ph, step, sep, item_accept, norm_start, norm_done;
  logic [1:0] ai, ak, ai1, ai2, ak1, ak2, bi, bk, ri, rk, j0, j1, j2;

  vec_t opa, opb, norm_out;
  merge_mode_t mode;
  prod_t prod [3];
  coord_t y;
  result_t pend_r;

  function automatic logic [1:0] inc3(logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

  function automatic logic [1:0] hi3(logic [3:0] c);
    case (c) inside
      [4'd0:4'd2]: return 2'd0;
      [4'd3:4'd5]: return 2'd1;
      default:     return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] lo3(logic [3:0] c);
    case (c) inside
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic [3:0] axis_ik(logic [3:0] a);
    logic [3:0] e;
    logic [3:0] f;
    e = a - AX_EDGE;
    f = a - AX_FB;
    if (a < AX_FB) return {a[1:0], 2'd0};
    if (a < AX_EDGE) return {2'd0, f[1:0]};
    return {hi3(e), lo3(e)};
  endfunction

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ext_a[j] = vs[j];
      ctr_a[j] = vs[3 + j];
      ext_b[j] = vs[15 + j];
      ctr_b[j] = vs[18 + j];
      for (int r = 0; r < 3; r++) begin
        bas_a[r][j] = vs[6 + 3 * r + j];
        bas_b[r][j] = vs[21 + 3 * r + j];
      end
    end
  end

  assign item_accept = item_valid && item_ready;
  assign {ai, ak} = axis_ik(ax);
  assign {bi, bk} = axis_ik(best_ax);
  assign ai1 = inc3(ai);
  assign ai2 = inc3(ai1);
  assign ak1 = inc3(ak);
  assign ak2 = inc3(ak1);
  assign ri = hi3(cnt);
  assign rk = lo3(cnt);
  assign j0 = cnt[1:0];
  assign j1 = inc3(j0);
  assign j2 = inc3(j1);
  assign sep = tax_r > sum_r;
  assign depth_c = fsub(sum_r, tax_r);
  assign ax_n = ax + 4'd1;

  always_comb begin
    opa = '0;
    opb = '0;
    mode = MODE_SUM;
    case (state)
      S_TDOT: begin
        opa = v_r;
        opb = bas_a[j0];
      end
      S_RDOT: begin
        opa = bas_a[ri];
        opb = bas_b[rk];
      end
      S_FA: begin
        opa = ext_b;
        for (int j = 0; j < 3; j++) opb[j] = fabsv(rm[ai][j]);
      end
      S_FB_RA: begin
        opa = ext_a;
        for (int j = 0; j < 3; j++) opb[j] = fabsv(rm[j][ak]);
      end
      S_FB_T: begin
        opa = t_r;
        for (int j = 0; j < 3; j++) opb[j] = rm[j][ak];
      end
      S_E_RA: begin
        opa[0] = ext_a[ai1];
        opb[0] = fabsv(rm[ai2][ak]);
        opa[1] = ext_a[ai2];
        opb[1] = fabsv(rm[ai1][ak]);
      end
      S_E_RB: begin
        opa[0] = ext_b[ak1];
        opb[0] = fabsv(rm[ai][ak2]);
        opa[1] = ext_b[ak2];
        opb[1] = fabsv(rm[ai][ak1]);
      end
      S_E_T: begin
        mode = MODE_DIFF;
        opa[0] = t_r[ai2];
        opb[0] = rm[ai1][ak];
        opa[1] = t_r[ai1];
        opb[1] = rm[ai2][ak];
      end
      S_CROSS: begin
        mode = MODE_DIFF;
        opa[0] = bas_a[bi][j1];
        opb[0] = bas_b[bk][j2];
        opa[1] = bas_a[bi][j2];
        opb[1] = bas_b[bk][j1];
      end
      S_NDOT: begin
        opa = n_r;
        opb = v_r;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    obod_lane u_lane (
      .clk  (clk),
      .op_a (opa[g]),
      .op_b (opb[g]),
      .prod (prod[g])
    );
  end

  obod_merge u_merge (
    .prod (prod),
    .mode (mode),
    .y    (y)
  );

  obod_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .n_in  (n_r),
    .n_out (norm_out),
    .done  (norm_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (item_accept && item_data.evaluate) state_next = S_VDIFF;
      S_VDIFF: state_next = S_TDOT;
      S_TDOT: if (ph && cnt == CNT_ROW) state_next = S_RDOT;
      S_RDOT: if (ph && cnt == CNT_MAT) state_next = S_FA;
      S_FA: if (ph) state_next = S_CHK1;
      S_FB_RA: if (ph) state_next = S_FB_T;
      S_FB_T: if (ph) state_next = S_CHK1;
      S_E_RA: if (ph) state_next = S_E_RB;
      S_E_RB: if (ph) state_next = S_E_T;
      S_E_T: if (ph) state_next = S_CHK1;
      S_CHK1: state_next = S_CHK2;
      S_CHK2: begin
        if (sep) begin
          state_next = S_OUT;
        end else if (ax == AX_LAST) begin
          state_next = S_NSEL;
        end else if (ax_n < AX_FB) begin
          state_next = S_FA;
        end else if (ax_n < AX_EDGE) begin
          state_next = S_FB_RA;
        end else begin
          state_next = S_E_RA;
        end
      end
      S_NSEL: state_next = (best_ax < AX_EDGE) ? S_NDOT : S_CROSS;
      S_CROSS: if (ph && cnt == CNT_ROW) state_next = S_NDOT;
      S_NDOT: if (ph) state_next = S_NGO;
      S_NGO: state_next = S_NWAIT;
      S_NWAIT: if (norm_done) state_next = S_OUT;
      S_OUT: if (!res_valid || res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == S_IDLE);
    norm_start = (state == S_NGO);
    step = (state == S_TDOT) || (state == S_RDOT) || (state == S_FA) ||
           (state == S_FB_RA) || (state == S_FB_T) || (state == S_E_RA) ||
           (state == S_E_RB) || (state == S_E_T) || (state == S_CROSS) ||
           (state == S_NDOT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      ph <= step ? ~ph : 1'b0;
      if (state == S_OUT && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_SLOTS; e++) begin
      if (item_accept && item_data.slot == SLOT_W'(e)) begin
        vs[3 * e]     <= item_data.comp_x;
        vs[3 * e + 1] <= item_data.comp_y;
        vs[3 * e + 2] <= item_data.comp_z;
      end
    end
    if (state == S_OUT && (!res_valid || res_ready)) begin
      res_data <= pend_r;
    end
    case (state)
      S_VDIFF: begin
        for (int j = 0; j < 3; j++) v_r[j] <= fsub(ctr_b[j], ctr_a[j]);
        cnt <= '0;
      end
      S_TDOT: begin
        if (ph) begin
          t_r[j0] <= y;
          cnt <= (cnt == CNT_ROW) ? '0 : cnt + 4'd1;
        end
      end
      S_RDOT: begin
        if (ph) begin
          rm[ri][rk] <= y;
          cnt <= cnt + 4'd1;
          ax <= '0;
        end
      end
      S_FA: begin
        if (ph) begin
          rb_r <= y;
          ra_r <= ext_a[ai];
          tax_r <= fabsv(t_r[ai]);
        end
      end
      S_FB_RA: begin
        if (ph) begin
          ra_r <= y;
          rb_r <= ext_b[ak];
        end
      end
      S_FB_T: if (ph) tax_r <= fabsv(y);
      S_E_RA: if (ph) ra_r <= y;
      S_E_RB: if (ph) rb_r <= y;
      S_E_T: if (ph) tax_r <= fabsv(y);
      S_CHK1: sum_r <= fadd(ra_r, rb_r);
      S_CHK2: begin
        if (sep) begin
          pend_r <= '0;
        end else if (ax == '0 || depth_c < best_depth) begin
          best_depth <= depth_c;
          best_ax <= ax;
        end
        ax <= ax_n;
      end
      S_NSEL: begin
        cnt <= '0;
        if (best_ax < AX_FB) begin
          n_r <= bas_a[bi];
        end else begin
          n_r <= bas_b[bk];
        end
      end
      S_CROSS: begin
        if (ph) begin
          n_r[j0] <= y;
          cnt <= cnt + 4'd1;
        end
      end
      S_NDOT: begin
        if (ph && y[COORD_W-1]) begin
          for (int j = 0; j < 3; j++) n_r[j] <= fneg(n_r[j]);
        end
      end
      S_NWAIT: begin
        if (norm_done) begin
          pend_r.overlap <= 1'b1;
          pend_r.depth <= best_depth;
          pend_r.normal_x <= norm_out[0];
          pend_r.normal_y <= norm_out[1];
          pend_r.normal_z <= norm_out[2];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/obod_check.sv =====
`timescale 1ns / 1ps

module obod_check
  import obod_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item_data,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  localparam coord_t UNIT = coord_t'(1) <<< FRAC_W;

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid after reset.");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("Stalled result transaction changed.");

  a_no_overlap_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.overlap |-> res_data.depth == '0 &&
      res_data.normal_x == '0 && res_data.normal_y == '0 && res_data.normal_z == '0)
    else $error("Separated boxes reported a nonzero depth or normal.");

  a_depth_sign: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.overlap |-> !res_data.depth[COORD_W-1])
    else $error("Overlap reported with a negative depth.");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.overlap |-> res_data.normal_x <= UNIT &&
      res_data.normal_x >= -UNIT && res_data.normal_y <= UNIT &&
      res_data.normal_y >= -UNIT && res_data.normal_z <= UNIT &&
      res_data.normal_z >= -UNIT)
    else $error("Normal component exceeds unit length.");

endmodule

bind oriented_box_overlap_depth obod_check u_obod_check (.*);
